// File: rtl/erf_pkg.sv
// Package for the escaped request framer: item and result structs, the
// queued job format, register indexes and the back-end byte sequence.
// No dependencies.
`timescale 1ns / 1ps

package erf_pkg;

	// Fixed widths and constants of the line format.
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam logic [7:0]  ESC_OFFSET   = 8'h20;
	localparam logic [7:0]  RESET_START  = 8'h02;
	localparam logic [7:0]  RESET_ESCAPE = 8'h10;
	localparam logic [7:0]  RESET_WRITE  = 8'h01;

	// Item kinds.
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_START_CODE   = 2'd0,
		REG_ESCAPE_CODE  = 2'd1,
		REG_WRITE_OPCODE = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  command;
		logic [31:0] address;
		logic [7:0]  byte_count;
		logic [7:0]  payload;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] escape_code;
		logic [7:0] write_opcode;
	} cfg_t;

	// One unit of work for the back end. A header job sends the start code,
	// command, address and count; a payload job sends only the body byte.
	// Either may close the frame with the checksum.
	typedef struct packed {
		logic        is_hdr;
		logic [7:0]  command;
		logic [31:0] address;
		logic [7:0]  body;
		logic        close;
		logic [7:0]  check;
	} job_t;

	// Byte positions the back end walks through.
	typedef enum logic [2:0] {
		STEP_START = 3'd0,
		STEP_CMD   = 3'd1,
		STEP_A0    = 3'd2,
		STEP_A1    = 3'd3,
		STEP_A2    = 3'd4,
		STEP_A3    = 3'd5,
		STEP_BODY  = 3'd6,
		STEP_CK    = 3'd7
	} step_t;

endpackage

// File: rtl/escaped_request_framer_unit.sv
// Top level of the escaped request framer: configuration registers and the
// front end, job queue and back end. Depends on erf_pkg and its modules.
//
// Channel   Handshake          Payload
// item      push / full        erf_pkg::in_item_t (req_type .. payload)
// result    empty / pop        erf_pkg::out_item_t (out_byte, frame_end, run_last)
// config    cfg_we             cfg_index, cfg_data
//
// Items are taken one per cycle while the job queue has room. The line side
// sends one byte per cycle while results are popped; a header is 7 to 14 line
// bytes, a payload 1 to 4, an escaped byte two. The back-end byte sequencer sets
// the sustained rate. Reset clears all control state; no clearing pass.
// A stalled result holds the back end; the queue keeps the front accepting.
`timescale 1ns / 1ps

module escaped_request_framer_unit #(
	parameter int unsigned QUEUE_DEPTH = erf_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  erf_pkg::in_item_t  item,
	input  logic               pop,
	output logic               empty,
	output erf_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	erf_pkg::cfg_t cfg_q;
	logic          job_valid;
	erf_pkg::job_t job;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	erf_pkg::job_t q_job;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code   <= erf_pkg::RESET_START;
			cfg_q.escape_code  <= erf_pkg::RESET_ESCAPE;
			cfg_q.write_opcode <= erf_pkg::RESET_WRITE;
		end else if (cfg_we) begin
			case (cfg_index)
				erf_pkg::REG_START_CODE:   cfg_q.start_code   <= cfg_data;
				erf_pkg::REG_ESCAPE_CODE:  cfg_q.escape_code  <= cfg_data;
				erf_pkg::REG_WRITE_OPCODE: cfg_q.write_opcode <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign full = q_full;

	erf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (q_full),
		.item      (item),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job)
	);

	erf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_valid),
		.wr_job (job),
		.full   (q_full),
		.rd     (q_pop),
		.rd_job (q_job),
		.empty  (q_empty)
	);

	erf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// File: rtl/erf_front.sv
// Front end of the escaped request framer: accepts items, tracks the open
// frame and its running sum, and turns each header, or payload of an open
// frame, into a job. Depends on erf_pkg.
`timescale 1ns / 1ps

module erf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            q_full,
	input  erf_pkg::in_item_t item,
	input  erf_pkg::cfg_t   cfg,
	output logic            job_valid,
	output erf_pkg::job_t   job
);

	logic       awaiting_q;
	logic [7:0] left_q;
	logic [7:0] sum_q;

	logic       accept;
	logic       is_hdr;
	logic       pay_ok;
	logic [7:0] hdr_sum;
	logic [7:0] new_sum;
	logic       hdr_open;
	logic       close;

	assign accept = push && !q_full;
	assign is_hdr = (item.req_type == erf_pkg::KIND_HEADER);
	assign pay_ok = awaiting_q && (left_q != 8'd0);

	// Header sum over command, address bytes and count.
	assign hdr_sum = item.command + item.address[7:0] + item.address[15:8]
		+ item.address[23:16] + item.address[31:24] + item.byte_count;

	assign hdr_open = (item.command == cfg.write_opcode) && (item.byte_count != 8'd0);
	assign new_sum  = is_hdr ? hdr_sum : sum_q + item.payload;
	assign close    = is_hdr ? !hdr_open : (left_q == 8'd1);

	// Job built from the current item.
	always_comb begin
		job_valid   = accept && (is_hdr || pay_ok);
		job.is_hdr  = is_hdr;
		job.command = item.command;
		job.address = item.address;
		job.body    = is_hdr ? item.byte_count : item.payload;
		job.close   = close;
		job.check   = ~new_sum;
	end

	// Frame state update on each transfer that makes a job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			left_q     <= 8'd0;
			sum_q      <= 8'd0;
		end else if (job_valid) begin
			if (close) begin
				awaiting_q <= 1'b0;
				left_q     <= 8'd0;
				sum_q      <= 8'd0;
			end else if (is_hdr) begin
				awaiting_q <= 1'b1;
				left_q     <= item.byte_count;
				sum_q      <= new_sum;
			end else begin
				left_q <= left_q - 8'd1;
				sum_q  <= new_sum;
			end
		end
	end

endmodule

// File: rtl/erf_queue.sv
// Job queue between the front and back ends of the framer.
// Depends on erf_pkg.
`timescale 1ns / 1ps

module erf_queue #(
	parameter int unsigned DEPTH = erf_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  erf_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd,
	output erf_pkg::job_t rd_job,
	output logic          empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	erf_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_wr;
	logic do_rd;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_job = mem_q[rp_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + PTR_W'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/erf_back.sv
// Back end of the framer: walks each job byte by byte, inserts escape
// pairs and drives the result register. Depends on erf_pkg.
`timescale 1ns / 1ps

module erf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  erf_pkg::cfg_t     cfg,
	input  logic              q_empty,
	input  erf_pkg::job_t     q_job,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output erf_pkg::out_item_t result
);

	erf_pkg::job_t      cur_q;
	logic               busy_q;
	erf_pkg::step_t     step_q;
	logic               esc_q;
	logic               out_valid_q;
	erf_pkg::out_item_t out_q;

	logic           advance;
	logic [7:0]     cur_byte;
	logic           escaped_step;
	logic           needs_esc;
	logic           byte_done;
	logic           job_end;
	logic           load;
	erf_pkg::step_t next_step;
	erf_pkg::out_item_t out_d;

	assign advance = busy_q && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// Byte at the current position and its escape need.
	always_comb begin
		cur_byte     = cur_q.check;
		escaped_step = 1'b1;
		next_step    = erf_pkg::STEP_CK;
		case (step_q)
			erf_pkg::STEP_START: begin
				cur_byte     = cfg.start_code;
				escaped_step = 1'b0;
				next_step    = erf_pkg::STEP_CMD;
			end
			erf_pkg::STEP_CMD: begin
				cur_byte     = cur_q.command;
				escaped_step = 1'b0;
				next_step    = erf_pkg::STEP_A0;
			end
			erf_pkg::STEP_A0: begin
				cur_byte  = cur_q.address[7:0];
				next_step = erf_pkg::STEP_A1;
			end
			erf_pkg::STEP_A1: begin
				cur_byte  = cur_q.address[15:8];
				next_step = erf_pkg::STEP_A2;
			end
			erf_pkg::STEP_A2: begin
				cur_byte  = cur_q.address[23:16];
				next_step = erf_pkg::STEP_A3;
			end
			erf_pkg::STEP_A3: begin
				cur_byte  = cur_q.address[31:24];
				next_step = erf_pkg::STEP_BODY;
			end
			erf_pkg::STEP_BODY: begin
				cur_byte  = cur_q.body;
				next_step = erf_pkg::STEP_CK;
			end
			default: begin
				cur_byte  = cur_q.check;
				next_step = erf_pkg::STEP_CK;
			end
		endcase
	end

	assign needs_esc = escaped_step
		&& ((cur_byte == cfg.start_code) || (cur_byte == cfg.escape_code));
	assign byte_done = advance && !(needs_esc && !esc_q);
	assign job_end   = byte_done && ((step_q == erf_pkg::STEP_CK)
		|| ((step_q == erf_pkg::STEP_BODY) && !cur_q.close));
	assign load      = (!busy_q || job_end) && !q_empty;
	assign q_pop     = load;

	// Next result: escape code first, then the offset byte.
	always_comb begin
		if (needs_esc && !esc_q) begin
			out_d.out_byte = cfg.escape_code;
		end else if (esc_q) begin
			out_d.out_byte = cur_byte + erf_pkg::ESC_OFFSET;
		end else begin
			out_d.out_byte = cur_byte;
		end
		out_d.frame_end = byte_done && (step_q == erf_pkg::STEP_CK);
		out_d.run_last  = job_end;
	end

	// Current job register.
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_job;
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= erf_pkg::STEP_START;
			esc_q  <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= q_job.is_hdr ? erf_pkg::STEP_START : erf_pkg::STEP_BODY;
				esc_q  <= 1'b0;
			end else begin
				if (job_end) begin
					busy_q <= 1'b0;
				end
				if (byte_done) begin
					step_q <= next_step;
					esc_q  <= 1'b0;
				end else if (advance) begin
					esc_q <= 1'b1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_d;
		end
	end

endmodule

// File: tb/escaped_request_framer_unit_tb.sv
// Self-checking testbench for escaped_request_framer_unit: a scoreboard class
// predicts the escaped line stream and checks each popped byte against it.
// Depends on erf_pkg and the escaped_request_framer_unit RTL.
`timescale 1ns / 1ps

module escaped_request_framer_unit_tb;
	import erf_pkg::*;

	// Line-stream predictor and store of expected bytes.
	class frame_scoreboard;
		out_item_t   expected_q[$];
		out_item_t   batch[$];
		logic [7:0]  start_code;
		logic [7:0]  escape_code;
		logic [7:0]  write_opcode;
		bit          frame_open;
		logic [7:0]  bytes_left;
		logic [7:0]  line_sum;
		int          errors;

		function new();
			start_code   = RESET_START;
			escape_code  = RESET_ESCAPE;
			write_opcode = RESET_WRITE;
			frame_open   = 1'b0;
			bytes_left   = '0;
			line_sum     = '0;
			errors       = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [7:0] value);
			case (idx)
				REG_START_CODE:   start_code = value;
				REG_ESCAPE_CODE:  escape_code = value;
				REG_WRITE_OPCODE: write_opcode = value;
				default: ;
			endcase
		endfunction

		function void put_raw(logic [7:0] b);
			batch.push_back(out_item_t'{out_byte: b, frame_end: 1'b0, run_last: 1'b0});
		endfunction

		// A byte that collides with either code goes out as an escape pair.
		function void put_stuffed(logic [7:0] b);
			if (b == start_code || b == escape_code) begin
				put_raw(escape_code);
				put_raw(b + ESC_OFFSET);
			end else begin
				put_raw(b);
			end
		endfunction

		// The checksum is the inverted byte sum; its last line byte ends the frame.
		function void close_frame();
			put_stuffed(~line_sum);
			batch[batch.size() - 1].frame_end = 1'b1;
			frame_open = 1'b0;
			bytes_left = '0;
			line_sum   = '0;
		endfunction

		function void note_input(in_item_t it);
			logic [7:0] ab;
			batch.delete();
			if (it.req_type == KIND_HEADER) begin
				// A header always starts a fresh frame, abandoning any open one.
				line_sum = it.command;
				put_raw(start_code);
				put_raw(it.command);
				for (int i = 0; i < 4; i++) begin
					ab = it.address[8*i +: 8];
					line_sum += ab;
					put_stuffed(ab);
				end
				line_sum += it.byte_count;
				put_stuffed(it.byte_count);
				if (it.command == write_opcode && it.byte_count != 0) begin
					frame_open = 1'b1;
					bytes_left = it.byte_count;
				end else begin
					close_frame();
				end
			end else begin
				// Payload with no open write frame produces nothing.
				if (!frame_open || bytes_left == 0)
					return;
				line_sum += it.payload;
				put_stuffed(it.payload);
				bytes_left--;
				if (bytes_left == 0)
					close_frame();
			end
			batch[batch.size() - 1].run_last = 1'b1;
			foreach (batch[k])
				expected_q.push_back(batch[k]);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected transfer, out_byte %02h frame_end %0b run_last %0b",
					$time, got.out_byte, got.frame_end, got.run_last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %02h, actual %02h",
					$time, want.out_byte, got.out_byte);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$display("%0t: frame_end expected %0b, actual %0b",
					$time, want.frame_end, got.frame_end);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$display("%0t: run_last expected %0b, actual %0b",
					$time, want.run_last, got.run_last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    item = '0;
	logic        pop = 1'b0;
	logic        empty;
	out_item_t   result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	frame_scoreboard sb = new();
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	escaped_request_framer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.pop       (pop),
		.empty     (empty),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("[escaped_request_framer_unit] ERROR");
		$finish;
	end

	// Bytes biased toward the current codes so escaping happens often.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return sb.start_code;
		if (r < 35)
			return sb.escape_code;
		if (r < 40)
			return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [31:0] pick_address();
		if ($urandom_range(3) == 0)
			return $urandom();
		return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
	endfunction

	// Offer one item from a falling edge and return at the falling edge after
	// its transfer, with push still high.
	task automatic send_item(in_item_t it);
		while (!calm && $urandom_range(99) < 17) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		sb.note_input(it);
		@(negedge clk);
	endtask

	// Header and payload items carry random junk in the fields they do not use.
	task automatic send_header(logic [7:0] cmd, logic [31:0] addr, logic [7:0] cnt);
		in_item_t it;
		it.req_type   = KIND_HEADER;
		it.command    = cmd;
		it.address    = addr;
		it.byte_count = cnt;
		it.payload    = 8'($urandom_range(255));
		send_item(it);
	endtask

	task automatic send_payload(logic [7:0] d);
		in_item_t it;
		it.req_type   = KIND_PAYLOAD;
		it.command    = 8'($urandom_range(255));
		it.address    = $urandom();
		it.byte_count = 8'($urandom_range(255));
		it.payload    = d;
		send_item(it);
	endtask

	// Wait for the block to drain; an ignored payload may still be in flight.
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// All three registers are written back to back with the enable held high.
	task automatic program_regs(logic [7:0] s, logic [7:0] e, logic [7:0] w);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_CODE;
		cfg_data  <= s;
		@(negedge clk);
		cfg_index <= REG_ESCAPE_CODE;
		cfg_data  <= e;
		@(negedge clk);
		cfg_index <= REG_WRITE_OPCODE;
		cfg_data  <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_START_CODE, s);
		sb.set_reg(REG_ESCAPE_CODE, e);
		sb.set_reg(REG_WRITE_OPCODE, w);
	endtask

	// Mostly complete write frames, some cut short, plus other headers and
	// stray payload bytes.
	task automatic run_traffic(int target);
		int sent;
		int r;
		int cnt;
		int cut;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(99);
			if (r < 65) begin
				cnt = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				cut = ($urandom_range(9) == 0) ? $urandom_range(cnt - 1) : cnt;
				send_header(sb.write_opcode, pick_address(), 8'(cnt));
				sent++;
				for (int k = 0; k < cut; k++) begin
					send_payload(pick_byte());
					sent++;
				end
			end else if (r < 88) begin
				send_header(8'($urandom_range(255)), pick_address(),
					8'($urandom_range(255)));
				sent++;
			end else begin
				send_payload(pick_byte());
				sent++;
			end
		end
	endtask

	// Result side: random pops, a long hold-off on request, no gaps while calm.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(99) >= 17);
			end
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(result);
		end
	end

	// Main sequence.
	initial begin
		int guard;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under the reset codes.
		send_payload(8'h55);
		send_header(8'h00, 32'h0000_0000, 8'h00);
		send_header(8'hFF, 32'hFFFF_FFFF, 8'hFF);
		send_header(8'h02, 32'h0210_1002, 8'h10);
		send_header(8'hFD, 32'h0000_0000, 8'h00);
		send_header(8'hEF, 32'h0000_0000, 8'h00);
		send_header(sb.write_opcode, 32'h1234_5678, 8'h00);
		send_header(sb.write_opcode, 32'h1002_1002, 8'h02);
		send_payload(8'h10);
		send_payload(8'h02);
		send_header(sb.write_opcode, 32'hA5A5_A5A5, 8'h03);
		send_payload(8'h00);
		send_header(sb.write_opcode, 32'h0000_0000, 8'h01);
		send_payload(8'hFF);
		send_payload(8'h02);
		send_header(sb.write_opcode, 32'hFFFF_0000, 8'hFF);
		send_payload(8'h7F);
		send_header(8'h80, 32'h8000_0000, 8'h80);
		send_payload(8'h33);

		// Low start code, high escape code; the receiver stalls long enough
		// for the input side to back up.
		program_regs(8'h00, 8'hFF, 8'hFF);
		hold_req = 1'b1;
		run_traffic(110);

		// Start code equal to escape code, with no idling on either side.
		program_regs(8'h7D, 8'h7D, 8'h00);
		calm = 1'b1;
		run_traffic(100);
		calm = 1'b0;

		program_regs(8'hFF, 8'h00, 8'h80);
		run_traffic(110);

		program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		run_traffic(110);

		// Drain, then keep watching for anything unexpected before the verdict.
		push <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (50) @(negedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected bytes never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[escaped_request_framer_unit] OK");
		end else begin
			$display("[escaped_request_framer_unit] ERROR");
		end
		$finish;
	end

endmodule
